[src/jaf_pkg.sv]
// ----------------------------------------------------------------------------
// jaf_pkg
// Shared types and constants for the joystick axis filter: register indexes,
// register reset values, throttle move directions and the twist map.
// ----------------------------------------------------------------------------
package jaf_pkg;

    // Default axis sample width
    localparam int AXIS_BITS_DEF = 10;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AXIS_HYST      = 3'd0,
        REG_IDLE_BAND      = 3'd1,
        REG_FAST_DELTA     = 3'd2,
        REG_FAST_PERSIST   = 3'd3,
        REG_MEDIUM_PERSIST = 3'd4,
        REG_TRACK_WINDOW   = 3'd5,
        REG_STABLE_SPAN    = 3'd6
    } reg_index_t;

    // Register reset values
    localparam logic [7:0] AXIS_HYST_RST      = 8'd4;
    localparam logic [6:0] IDLE_BAND_RST      = 7'd3;
    localparam logic [6:0] FAST_DELTA_RST     = 7'd8;
    localparam logic [9:0] FAST_PERSIST_RST   = 10'd6;
    localparam logic [9:0] MEDIUM_PERSIST_RST = 10'd250;
    localparam logic [9:0] TRACK_WINDOW_RST   = 10'd100;
    localparam logic [6:0] STABLE_SPAN_RST    = 7'd3;

    // Throttle move direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Twist map: linear on both sides with a flat band around the center
    localparam logic [5:0] TWIST_MAP [64] = '{
        6'd0,  6'd1,  6'd3,  6'd4,  6'd5,  6'd7,  6'd8,  6'd9,
        6'd11, 6'd12, 6'd13, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20,
        6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30, 6'd31,
        6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
        6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd33,
        6'd34, 6'd36, 6'd37, 6'd38, 6'd39, 6'd41, 6'd42, 6'd43,
        6'd44, 6'd46, 6'd47, 6'd48, 6'd49, 6'd51, 6'd52, 6'd53,
        6'd54, 6'd56, 6'd57, 6'd58, 6'd59, 6'd61, 6'd62, 6'd63
    };

endpackage

[src/joystick_axis_filter.sv]
// ----------------------------------------------------------------------------
// joystick_axis_filter
// Filters one raw joystick sample into one snapshot: X/Y hysteresis, twist
// deadband map with unit slew, throttle direction-persistence filter.
// ----------------------------------------------------------------------------
// Usage: one sample transfer can be taken on every clock unless the output
// stalls; its snapshot shows on the output in the next cycle, held in a
// single output register, and a new sample is taken in the same cycle the
// held snapshot is taken downstream. All filter state updates from the
// sample and the current state. A clear transfer (tuser high) produces no
// snapshot and makes the next sample reload the state directly. Write
// configuration registers only while no snapshot is pending.
module joystick_axis_filter #(
    parameter int AXIS_BITS = jaf_pkg::AXIS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // buttons_in[15:0], x_raw, y_raw, twist_raw[7:0], throttle_raw[6:0],
    // hat_in[7:0], zero fill
    input  logic [((39 + 2*AXIS_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd: 0 sample, 1 clear
    input  logic                                s_axis_tuser,
    // Snapshot output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // buttons_out[15:0], x_out, y_out, z_out[5:0], slider_out[6:0],
    // hat_out[7:0], zero fill
    output logic [((37 + 2*AXIS_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jaf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [jaf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import jaf_pkg::*;

    localparam int OUT_BITS = ((37 + 2*AXIS_BITS + 7) / 8) * 8;
    localparam int OUT_USED = 37 + 2*AXIS_BITS;
    localparam int XI = 16;
    localparam int YI = XI + AXIS_BITS;
    localparam int TI = YI + AXIS_BITS;
    localparam int SI = TI + 8;
    localparam int HI = SI + 7;

    // Configuration registers
    logic [7:0] axis_hyst_reg;
    logic [6:0] idle_band_reg;
    logic [6:0] fast_delta_reg;
    logic [9:0] fast_persist_reg;
    logic [9:0] medium_persist_reg;
    logic [9:0] track_window_reg;
    logic [6:0] stable_span_reg;

    // Filter state
    logic                 primed_reg,   primed_next;
    logic [AXIS_BITS-1:0] x_held_reg,   x_held_next;
    logic [AXIS_BITS-1:0] y_held_reg,   y_held_next;
    logic [5:0]           z_held_reg,   z_held_next;
    logic [6:0]           slider_reg,   slider_next;
    dir_t                 dir_reg,      dir_next;
    logic                 tracking_reg, tracking_next;
    logic [9:0]           persist_reg,  persist_next;
    logic [9:0]           wcount_reg,   wcount_next;
    logic [6:0]           wmin_reg,     wmin_next;
    logic [6:0]           wmax_reg,     wmax_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg,  out_data_next;

    // Input fields
    logic                 in_fire;
    logic                 cmd;
    logic [15:0]          buttons_in;
    logic [AXIS_BITS-1:0] x_raw;
    logic [AXIS_BITS-1:0] y_raw;
    logic [7:0]           twist_raw;
    logic [6:0]           throttle_raw;
    logic [7:0]           hat_in;
    logic [5:0]           z_map;

    // Working values
    logic [AXIS_BITS:0]   hyst_ext;
    logic [6:0]           mag;
    dir_t                 dir_in;
    logic                 fast;
    logic [9:0]           req;
    logic [9:0]           pcount;
    logic [9:0]           wcount;
    logic [6:0]           wmin;
    logic [6:0]           wmax;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cmd          = s_axis_tuser;
    assign buttons_in   = s_axis_tdata[15:0];
    assign x_raw        = s_axis_tdata[XI +: AXIS_BITS];
    assign y_raw        = s_axis_tdata[YI +: AXIS_BITS];
    assign twist_raw    = s_axis_tdata[TI +: 8];
    assign throttle_raw = s_axis_tdata[SI +: 7];
    assign hat_in       = s_axis_tdata[HI +: 8];
    assign z_map        = TWIST_MAP[twist_raw[5:0]];
    assign hyst_ext     = (AXIS_BITS + 1)'(axis_hyst_reg);

    // Hysteresis: follow the raw value at a distance of h once it leaves the band
    function automatic logic [AXIS_BITS-1:0] hyst_step(
        input logic [AXIS_BITS-1:0] raw,
        input logic [AXIS_BITS-1:0] held,
        input logic [AXIS_BITS:0]   h
    );
        logic [AXIS_BITS:0] raw_w;
        logic [AXIS_BITS:0] held_w;
        raw_w  = {1'b0, raw};
        held_w = {1'b0, held};
        if (raw_w > held_w + h)
            hyst_step = AXIS_BITS'(raw_w - h);
        else if (raw_w + h < held_w)
            hyst_step = AXIS_BITS'(raw_w + h);
        else
            hyst_step = held;
    endfunction

    // Compute next filter state and snapshot
    always_comb
    begin
        primed_next   = primed_reg;
        x_held_next   = x_held_reg;
        y_held_next   = y_held_reg;
        z_held_next   = z_held_reg;
        slider_next   = slider_reg;
        dir_next      = dir_reg;
        tracking_next = tracking_reg;
        persist_next  = persist_reg;
        wcount_next   = wcount_reg;
        wmin_next     = wmin_reg;
        wmax_next     = wmax_reg;
        mag           = '0;
        dir_in        = DIR_NONE;
        fast          = 1'b0;
        req           = '0;
        pcount        = persist_reg;
        wcount        = wcount_reg;
        wmin          = wmin_reg;
        wmax          = wmax_reg;

        if (in_fire)
        begin
            if (cmd)
            begin
                primed_next = 1'b0;
            end
            else if (!primed_reg)
            begin
                // Load state directly from the first sample
                x_held_next   = x_raw;
                y_held_next   = y_raw;
                slider_next   = throttle_raw;
                z_held_next   = z_map;
                dir_next      = DIR_NONE;
                tracking_next = 1'b0;
                persist_next  = '0;
                wcount_next   = '0;
                wmin_next     = throttle_raw;
                wmax_next     = throttle_raw;
                primed_next   = 1'b1;
            end
            else
            begin
                x_held_next = hyst_step(x_raw, x_held_reg, hyst_ext);
                y_held_next = hyst_step(y_raw, y_held_reg, hyst_ext);

                // Slew twist one step toward the mapped value
                if (z_map > z_held_reg)
                    z_held_next = z_held_reg + 6'd1;
                else if (z_map < z_held_reg)
                    z_held_next = z_held_reg - 6'd1;

                if (tracking_reg)
                begin
                    // Track the raw throttle and watch the span per window
                    slider_next = throttle_raw;
                    if (wcount == '0)
                    begin
                        wmin   = throttle_raw;
                        wmax   = throttle_raw;
                        wcount = 10'd1;
                    end
                    else
                    begin
                        if (throttle_raw < wmin)
                            wmin = throttle_raw;
                        if (throttle_raw > wmax)
                            wmax = throttle_raw;
                        if (wcount < track_window_reg)
                            wcount = wcount + 10'd1;
                    end
                    if (wcount >= track_window_reg)
                    begin
                        if (wmax - wmin <= stable_span_reg)
                            tracking_next = 1'b0;
                        wcount = '0;
                        wmin   = throttle_raw;
                        wmax   = throttle_raw;
                    end
                    wcount_next  = wcount;
                    wmin_next    = wmin;
                    wmax_next    = wmax;
                    dir_next     = DIR_NONE;
                    persist_next = '0;
                end
                else
                begin
                    if (throttle_raw > slider_reg)
                    begin
                        mag    = throttle_raw - slider_reg;
                        dir_in = DIR_UP;
                    end
                    else
                    begin
                        mag    = slider_reg - throttle_raw;
                        dir_in = DIR_DOWN;
                    end

                    if (mag <= idle_band_reg)
                    begin
                        dir_next     = DIR_NONE;
                        persist_next = '0;
                    end
                    else
                    begin
                        // Count samples moving the same way
                        fast = (mag >= fast_delta_reg);
                        req  = fast ? fast_persist_reg : medium_persist_reg;
                        if (dir_in != dir_reg)
                        begin
                            dir_next = dir_in;
                            pcount   = 10'd1;
                        end
                        else if (pcount < req)
                        begin
                            pcount = pcount + 10'd1;
                        end
                        persist_next = pcount;
                        if (pcount >= req)
                        begin
                            slider_next  = throttle_raw;
                            dir_next     = DIR_NONE;
                            persist_next = '0;
                            if (fast)
                            begin
                                tracking_next = 1'b1;
                                wcount_next   = 10'd1;
                                wmin_next     = throttle_raw;
                                wmax_next     = throttle_raw;
                            end
                        end
                    end
                end
            end
        end
    end

    // Snapshot payload and output valid
    always_comb
    begin
        out_data_next = '0;
        out_data_next[OUT_USED-1:0] = {hat_in, slider_next, z_held_next,
                                       y_held_next, x_held_next, buttons_in};
        if (in_fire && !cmd)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold configuration, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_hyst_reg      <= AXIS_HYST_RST;
            idle_band_reg      <= IDLE_BAND_RST;
            fast_delta_reg     <= FAST_DELTA_RST;
            fast_persist_reg   <= FAST_PERSIST_RST;
            medium_persist_reg <= MEDIUM_PERSIST_RST;
            track_window_reg   <= TRACK_WINDOW_RST;
            stable_span_reg    <= STABLE_SPAN_RST;
            primed_reg         <= 1'b0;
            x_held_reg         <= '0;
            y_held_reg         <= '0;
            z_held_reg         <= '0;
            slider_reg         <= '0;
            dir_reg            <= DIR_NONE;
            tracking_reg       <= 1'b0;
            persist_reg        <= '0;
            wcount_reg         <= '0;
            wmin_reg           <= '0;
            wmax_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_AXIS_HYST:      axis_hyst_reg      <= cfg_data[7:0];
                    REG_IDLE_BAND:      idle_band_reg      <= cfg_data[6:0];
                    REG_FAST_DELTA:     fast_delta_reg     <= cfg_data[6:0];
                    REG_FAST_PERSIST:   fast_persist_reg   <= cfg_data;
                    REG_MEDIUM_PERSIST: medium_persist_reg <= cfg_data;
                    REG_TRACK_WINDOW:   track_window_reg   <= cfg_data;
                    REG_STABLE_SPAN:    stable_span_reg    <= cfg_data[6:0];
                    default:            ;
                endcase
            end
            primed_reg    <= primed_next;
            x_held_reg    <= x_held_next;
            y_held_reg    <= y_held_next;
            z_held_reg    <= z_held_next;
            slider_reg    <= slider_next;
            dir_reg       <= dir_next;
            tracking_reg  <= tracking_next;
            persist_reg   <= persist_next;
            wcount_reg    <= wcount_next;
            wmin_reg      <= wmin_next;
            wmax_reg      <= wmax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load snapshot payload on a sample transfer
    always_ff @(posedge clk)
    begin
        if (in_fire && !cmd)
            out_data_reg <= out_data_next;
    end

endmodule

[tb/joystick_axis_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_axis_filter_tb
// Self-checking bench for the joystick axis filter. A cycle-free predictor
// tracks the filter state and register file and queues one snapshot per
// sample transfer. A monitor compares every snapshot taken from the output
// with the oldest queued one, field by field. Stimulus runs directed corner
// cases first, then random throttle segments that drive the persistence and
// tracking logic, under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module joystick_axis_filter_tb;

    import jaf_pkg::*;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam int   PRINT_CAP  = 40;

    typedef struct packed {
        logic        cmd;
        logic [15:0] buttons;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  twist;
        logic [6:0]  throttle;
        logic [7:0]  hat;
    } sample_t;

    typedef struct packed {
        logic [15:0] buttons;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [5:0]  z;
        logic [6:0]  slider;
        logic [7:0]  hat;
    } snapshot_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // buttons_in[15:0], x_raw[25:16], y_raw[35:26], twist_raw[43:36],
    // throttle_raw[50:44], hat_in[58:51], zero fill
    logic [63:0] s_axis_tdata;
    // cmd
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // buttons_out[15:0], x_out[25:16], y_out[35:26], z_out[41:36],
    // slider_out[48:42], hat_out[56:49], zero fill
    logic [63:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Predicted register file
    logic [7:0] band_hyst   = AXIS_HYST_RST;
    logic [6:0] band_idle   = IDLE_BAND_RST;
    logic [6:0] fast_step   = FAST_DELTA_RST;
    logic [9:0] fast_need   = FAST_PERSIST_RST;
    logic [9:0] medium_need = MEDIUM_PERSIST_RST;
    logic [9:0] window_len  = TRACK_WINDOW_RST;
    logic [6:0] span_limit  = STABLE_SPAN_RST;

    // Predicted filter state
    logic       seeded      = 1'b0;
    logic [9:0] x_hold      = '0;
    logic [9:0] y_hold      = '0;
    logic [5:0] z_hold      = '0;
    logic [6:0] slider_hold = '0;
    dir_t       move_dir    = DIR_NONE;
    logic       tracking    = 1'b0;
    logic [9:0] persist_cnt = '0;
    logic [9:0] window_cnt  = '0;
    logic [6:0] window_lo   = '0;
    logic [6:0] window_hi   = '0;

    snapshot_t snap_expect_q[$];
    int        err_count    = 0;

    // Idle control shared with the driving processes
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_left    = 0;

    // Random throttle segment and axis walk state
    int seg_target = 64;
    int seg_left   = 0;
    int seg_jit    = 0;
    int x_walk     = 512;
    int y_walk     = 512;

    joystick_axis_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic int apply_band(int raw, int held, int half);
        if (raw > held + half)
            return raw - half;
        if (raw + half < held)
            return raw + half;
        return held;
    endfunction

    function automatic void take_reg_write(reg_index_t idx, logic [9:0] val);
        case (idx)
            REG_AXIS_HYST:      band_hyst   = val[7:0];
            REG_IDLE_BAND:      band_idle   = val[6:0];
            REG_FAST_DELTA:     fast_step   = val[6:0];
            REG_FAST_PERSIST:   fast_need   = val;
            REG_MEDIUM_PERSIST: medium_need = val;
            REG_TRACK_WINDOW:   window_len  = val;
            REG_STABLE_SPAN:    span_limit  = val[6:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_throttle(logic [6:0] raw);
        int         mag;
        logic [9:0] need;
        dir_t       dir;
        logic       is_fast;
        // Tracking: follow raw, end tracking once a window stays narrow
        if (tracking)
        begin
            slider_hold = raw;
            if (window_cnt == 0)
            begin
                window_lo  = raw;
                window_hi  = raw;
                window_cnt = 1;
            end
            else
            begin
                if (raw < window_lo)
                    window_lo = raw;
                if (raw > window_hi)
                    window_hi = raw;
                if (window_cnt < window_len)
                    window_cnt++;
            end
            if (window_cnt >= window_len)
            begin
                if (int'(window_hi) - int'(window_lo) <= int'(span_limit))
                    tracking = 1'b0;
                window_cnt = 0;
                window_lo  = raw;
                window_hi  = raw;
            end
            move_dir    = DIR_NONE;
            persist_cnt = 0;
            return;
        end
        if (raw > slider_hold)
        begin
            mag = int'(raw) - int'(slider_hold);
            dir = DIR_UP;
        end
        else
        begin
            mag = int'(slider_hold) - int'(raw);
            dir = DIR_DOWN;
        end
        // Small moves are idle: drop any pending direction
        if (mag <= int'(band_idle))
        begin
            move_dir    = DIR_NONE;
            persist_cnt = 0;
            return;
        end
        is_fast = (mag >= int'(fast_step));
        need    = is_fast ? fast_need : medium_need;
        if (dir != move_dir)
        begin
            move_dir    = dir;
            persist_cnt = 1;
        end
        else if (persist_cnt < need)
            persist_cnt++;
        // Accept the move once it has persisted long enough
        if (persist_cnt >= need)
        begin
            slider_hold = raw;
            move_dir    = DIR_NONE;
            persist_cnt = 0;
            if (is_fast)
            begin
                tracking   = 1'b1;
                window_cnt = 1;
                window_lo  = raw;
                window_hi  = raw;
            end
        end
    endfunction

    function automatic void filter_sample(sample_t s);
        snapshot_t  snap;
        logic [5:0] z_target;
        if (s.cmd == CMD_CLEAR)
        begin
            seeded = 1'b0;
            return;
        end
        z_target = TWIST_MAP[s.twist[5:0]];
        if (!seeded)
        begin
            // Load the state directly from the first sample
            x_hold      = s.x;
            y_hold      = s.y;
            slider_hold = s.throttle;
            z_hold      = z_target;
            move_dir    = DIR_NONE;
            tracking    = 1'b0;
            persist_cnt = 0;
            window_cnt  = 0;
            window_lo   = s.throttle;
            window_hi   = s.throttle;
            seeded      = 1'b1;
        end
        else
        begin
            x_hold = 10'(apply_band(s.x, x_hold, band_hyst));
            y_hold = 10'(apply_band(s.y, y_hold, band_hyst));
            advance_throttle(s.throttle);
            // Slew twist one step toward the mapped value
            if (z_target > z_hold)
                z_hold++;
            else if (z_target < z_hold)
                z_hold--;
        end
        snap.buttons = s.buttons;
        snap.x       = x_hold;
        snap.y       = y_hold;
        snap.z       = z_hold;
        snap.slider  = slider_hold;
        snap.hat     = s.hat;
        snap_expect_q.push_back(snap);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("MISMATCH %s: got %0d, expected %0d at %0t",
                     what, got, want, $realtime);
    endtask

    task automatic check_snapshot(logic [63:0] d);
        snapshot_t want;
        if (snap_expect_q.size() == 0)
        begin
            report_mismatch("snapshot with none pending", d[15:0], 0);
            return;
        end
        want = snap_expect_q.pop_front();
        if (d[15:0] != want.buttons)
            report_mismatch("buttons_out", d[15:0], want.buttons);
        if (d[25:16] != want.x)
            report_mismatch("x_out", d[25:16], want.x);
        if (d[35:26] != want.y)
            report_mismatch("y_out", d[35:26], want.y);
        if (d[41:36] != want.z)
            report_mismatch("z_out", d[41:36], want.z);
        if (d[48:42] != want.slider)
            report_mismatch("slider_out", d[48:42], want.slider);
        if (d[56:49] != want.hat)
            report_mismatch("hat_out", d[56:49], want.hat);
    endtask

    // Observe every transfer at the edge where it happens
    always @(posedge clk)
    begin
        sample_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                take_reg_write(reg_index_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.cmd      = s_axis_tuser;
                seen.buttons  = s_axis_tdata[15:0];
                seen.x        = s_axis_tdata[25:16];
                seen.y        = s_axis_tdata[35:26];
                seen.twist    = s_axis_tdata[43:36];
                seen.throttle = s_axis_tdata[50:44];
                seen.hat      = s_axis_tdata[58:51];
                filter_sample(seen);
            end
            if (m_axis_tvalid && m_axis_tready)
                check_snapshot(m_axis_tdata);
        end
    end

    // Output ready: random stalls, or a long hold when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.cmd;
        s_axis_tdata  <= {5'd0, s.hat, s.throttle, s.twist, s.y, s.x, s.buttons};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_fields(logic cmd, logic [15:0] buttons, logic [9:0] x,
                               logic [9:0] y, logic [7:0] twist,
                               logic [6:0] throttle, logic [7:0] hat);
        sample_t s;
        s.cmd      = cmd;
        s.buttons  = buttons;
        s.x        = x;
        s.y        = y;
        s.twist    = twist;
        s.throttle = throttle;
        s.hat      = hat;
        send_sample(s);
    endtask

    // Drop valid and wait until every pending snapshot has been taken; the
    // extra edge lets the monitor queue a transfer taken at the current edge
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (snap_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(int hyst, int idle, int fast, int fast_cnt,
                                  int medium_cnt, int window, int span);
        settle();
        write_reg(REG_AXIS_HYST, hyst);
        write_reg(REG_IDLE_BAND, idle);
        write_reg(REG_FAST_DELTA, fast);
        write_reg(REG_FAST_PERSIST, fast_cnt);
        write_reg(REG_MEDIUM_PERSIST, medium_cnt);
        write_reg(REG_TRACK_WINDOW, window);
        write_reg(REG_STABLE_SPAN, span);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------

    function automatic int clamp(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int walk_axis(int pos);
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return (pick & 1) ? 1023 : 0;
        if (pick < 15)
            return $urandom_range(0, 1023);
        return clamp(pos + int'($urandom_range(0, 24)) - 12, 1023);
    endfunction

    // Throttle mostly comes in segments held near one target, so moves persist
    // long enough to be accepted and tracking windows can settle
    function automatic sample_t random_sample();
        sample_t s;
        int      pick;
        int      thr;
        s.cmd     = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_SAMPLE;
        s.buttons = 16'($urandom);
        s.twist   = 8'($urandom);
        s.hat     = 8'($urandom);
        x_walk    = walk_axis(x_walk);
        y_walk    = walk_axis(y_walk);
        s.x       = 10'(x_walk);
        s.y       = 10'(y_walk);
        if (seg_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                seg_jit  = 127;
                seg_left = $urandom_range(1, 4);
            end
            else
            begin
                seg_target = (pick < 18) ? ((pick & 1) ? 127 : 0) : $urandom_range(0, 127);
                seg_left   = $urandom_range(1, 20);
                pick       = $urandom_range(99);
                seg_jit    = (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                           : $urandom_range(4, 20);
            end
        end
        seg_left--;
        thr        = clamp(seg_target + int'($urandom_range(0, 2 * seg_jit)) - seg_jit, 127);
        s.throttle = 7'(thr);
        return s;
    endfunction

    // Random traffic with a full pause halfway through
    task automatic run_phase(int count, int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                settle();
            send_sample(random_sample());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: loading, pass-through, field extremes, twist map and
    // slew, clear and reload, a fast throttle move into tracking
    task automatic test_first_samples();
        send_fields(CMD_CLEAR, 16'h1234, 10'd5, 10'd6, 8'd7, 7'd8, 8'h9a);
        send_fields(CMD_SAMPLE, 16'h0000, 10'd0, 10'd0, 8'h00, 7'd0, 8'h00);
        send_fields(CMD_SAMPLE, 16'hffff, 10'd1023, 10'd1023, 8'hff, 7'd127, 8'hff);
        send_fields(CMD_SAMPLE, 16'h5a5a, 10'd1021, 10'd1016, 8'hc0, 7'd126, 8'ha5);
        send_fields(CMD_SAMPLE, 16'ha5a5, 10'd2, 10'd1023, 8'h3f, 7'd0, 8'h5a);
        send_fields(CMD_CLEAR, 16'hffff, 10'd1023, 10'd0, 8'hff, 7'd127, 8'hff);
        send_fields(CMD_SAMPLE, 16'h0001, 10'd512, 10'd511, 8'd32, 7'd60, 8'h01);
        send_fields(CMD_SAMPLE, 16'h0002, 10'd515, 10'd507, 8'd24, 7'd62, 8'h02);
        send_fields(CMD_SAMPLE, 16'h0004, 10'd517, 10'd506, 8'd39, 7'd57, 8'h04);
        send_fields(CMD_SAMPLE, 16'h0008, 10'd520, 10'd500, 8'd0, 7'd60, 8'h08);
        for (int i = 0; i < 6; i++)
            send_fields(CMD_SAMPLE, 16'h0100 << i, 10'd520, 10'd500, 8'd0, 7'd70, 8'h10);
        send_fields(CMD_SAMPLE, 16'h8000, 10'd520, 10'd500, 8'd63, 7'd71, 8'h20);
        send_fields(CMD_SAMPLE, 16'h4000, 10'd520, 10'd500, 8'd63, 7'd5, 8'h40);
        settle();
    endtask

    // Every register at its low extreme, but medium persistence at 1 (zero fast
    // persistence and zero window included), then at its high extreme
    task automatic test_register_extremes();
        apply_settings(0, 0, 0, 0, 1, 0, 0);
        send_fields(CMD_SAMPLE, 16'h0f0f, 10'd500, 10'd3, 8'd10, 7'd10, 8'h0f);
        send_fields(CMD_SAMPLE, 16'hf0f0, 10'd501, 10'd2, 8'd11, 7'd11, 8'hf0);
        send_fields(CMD_SAMPLE, 16'h00ff, 10'd501, 10'd2, 8'd12, 7'd11, 8'h33);
        send_fields(CMD_SAMPLE, 16'hff00, 10'd0, 10'd1023, 8'd13, 7'd50, 8'hcc);
        apply_settings(255, 127, 127, 1023, 1023, 1023, 127);
        send_fields(CMD_SAMPLE, 16'h1111, 10'd1023, 10'd0, 8'd50, 7'd127, 8'h11);
        send_fields(CMD_SAMPLE, 16'h2222, 10'd700, 10'd300, 8'd50, 7'd0, 8'h22);
        send_fields(CMD_SAMPLE, 16'h4444, 10'd0, 10'd1023, 8'd50, 7'd64, 8'h44);
        settle();
    endtask

    task automatic test_steady_stream();
        apply_settings(4, 3, 8, 3, 5, 6, 3);
        run_phase(110, 0, 0);
    endtask

    task automatic test_sender_gaps();
        apply_settings(2, 1, 6, 2, 4, 8, 2);
        run_phase(110, 68, 0);
    endtask

    task automatic test_receiver_stalls();
        apply_settings(12, 5, 20, 1, 8, 3, 6);
        run_phase(110, 0, 68);
    endtask

    task automatic test_mixed_idling();
        apply_settings(40, 2, 10, 4, 10, 12, 4);
        run_phase(90, 24, 24);
    endtask

    // Hold the output off long enough that the input stalls behind it
    task automatic test_output_backpressure();
        apply_settings(4, 3, 8, 6, 12, 10, 3);
        hold_req = 300;
        run_phase(40, 0, 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SAMPLE;
        cfg_valid     = 1'b0;
        cfg_index     = REG_AXIS_HYST;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_samples();
        test_register_extremes();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_backpressure();

        // Wait out the last snapshots, then let the bench idle before the final check
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 5000 && snap_expect_q.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (snap_expect_q.size() != 0)
            report_mismatch("snapshots never produced", 0, snap_expect_q.size());

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
